FILE: hdl/rc4_pkg.sv
package rc4_pkg;

  localparam int unsigned KeyBits   = 40;
  localparam int unsigned ByteBits  = 8;
  localparam int unsigned TableSize = 256;

  localparam logic [ByteBits-1:0] KeyTail0 = 8'he5;
  localparam logic [ByteBits-1:0] KeyTail1 = 8'h38;
  localparam logic [ByteBits-1:0] KeyTail2 = 8'hb0;

  localparam logic ModeRekey = 1'b0;
  localparam logic ModeCrypt = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [ByteBits-1:0] data_byte;
    logic                buffer_end;
  } in_word_t;

  typedef struct packed {
    logic [ByteBits-1:0] result_byte;
    logic                block_end;
  } out_word_t;

  typedef struct packed {
    logic                clr;
    logic                re;
    logic [ByteBits-1:0] raddr;
    logic                we;
    logic [ByteBits-1:0] waddr;
    logic [ByteBits-1:0] wdata;
  } perm_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_C_RDJ,
    ST_C_WRI,
    ST_C_WRJ,
    ST_C_KS,
    ST_K_RD,
    ST_K_ACC,
    ST_K_WRK,
    ST_K_WRA
  } rc4_state_e;

  function automatic logic [ByteBits-1:0] key_byte(input logic [KeyBits-1:0] key,
                                                   input logic [2:0]         idx);
    logic [ByteBits-1:0] b;
    case (idx)
      3'd0:    b = key[7:0];
      3'd1:    b = key[15:8];
      3'd2:    b = key[23:16];
      3'd3:    b = key[31:24];
      3'd4:    b = key[39:32];
      3'd5:    b = KeyTail0;
      3'd6:    b = KeyTail1;
      3'd7:    b = KeyTail2;
      default: b = KeyTail2;
    endcase
    return b;
  endfunction

endpackage

FILE: hdl/rc4_perm.sv
module rc4_perm (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rc4_pkg::perm_req_t                req_i,
  output logic [rc4_pkg::ByteBits-1:0]      rdata_o
);
  import rc4_pkg::*;

  logic [ByteBits-1:0]  mem [TableSize];
  logic [ByteBits-1:0]  mem_q;
  logic [TableSize-1:0] valid_q;
  logic                 fwd_q;
  logic                 hit_q;
  logic [ByteBits-1:0]  fwd_data_q;
  logic [ByteBits-1:0]  addr_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      mem_q <= mem[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.clr) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      fwd_q      <= req_i.we && (req_i.waddr == req_i.raddr);
      fwd_data_q <= req_i.wdata;
      hit_q      <= valid_q[req_i.raddr];
      addr_q     <= req_i.raddr;
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : (hit_q ? mem_q : addr_q);

endmodule

FILE: hdl/rc4_ctrl.sv
module rc4_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [rc4_pkg::KeyBits-1:0]   key_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rc4_pkg::in_word_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rc4_pkg::out_word_t            out_data_o,
  output rc4_pkg::perm_req_t            req_o,
  input  logic [rc4_pkg::ByteBits-1:0]  rdata_i
);
  import rc4_pkg::*;

  rc4_state_e          state_q, state_d;
  logic [ByteBits-1:0] i_q, i_d, j_q, j_d;
  logic [ByteBits-1:0] si_q, si_d, sj_q, sj_d;
  logic [ByteBits-1:0] k_q, k_d, acc_q, acc_d;
  logic [ByteBits-1:0] data_q, data_d;
  logic                end_q, end_d;
  logic                out_valid_q, out_valid_d;
  out_word_t           out_q, out_d;
  logic                accept;
  logic                out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_data_i.mode == ModeCrypt) ? ST_C_RDJ : ST_K_RD;
        end
      end
      ST_C_RDJ: state_d = ST_C_WRI;
      ST_C_WRI: state_d = ST_C_WRJ;
      ST_C_WRJ: state_d = ST_C_KS;
      ST_C_KS: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_K_RD:  state_d = ST_K_ACC;
      ST_K_ACC: state_d = ST_K_WRK;
      ST_K_WRK: state_d = ST_K_WRA;
      ST_K_WRA: state_d = (k_q == 8'hff) ? ST_IDLE : ST_K_ACC;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_o       = '0;
    i_d         = i_q;
    j_d         = j_q;
    si_d        = si_q;
    sj_d        = sj_q;
    k_d         = k_q;
    acc_d       = acc_q;
    data_d      = data_q;
    end_d       = end_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_data_i.mode == ModeCrypt) begin
            i_d         = i_q + 8'd1;
            req_o.re    = 1'b1;
            req_o.raddr = i_q + 8'd1;
            data_d      = in_data_i.data_byte;
            end_d       = in_data_i.buffer_end;
          end else begin
            req_o.clr = 1'b1;
            k_d       = '0;
            acc_d     = '0;
          end
        end
      end
      ST_C_RDJ: begin
        si_d        = rdata_i;
        j_d         = j_q + rdata_i;
        req_o.re    = 1'b1;
        req_o.raddr = j_q + rdata_i;
      end
      ST_C_WRI: begin
        sj_d        = rdata_i;
        req_o.we    = 1'b1;
        req_o.waddr = i_q;
        req_o.wdata = rdata_i;
      end
      ST_C_WRJ: begin
        req_o.we    = 1'b1;
        req_o.waddr = j_q;
        req_o.wdata = si_q;
        req_o.re    = 1'b1;
        req_o.raddr = si_q + sj_q;
      end
      ST_C_KS: begin
        if (out_free) begin
          out_d.result_byte = data_q ^ rdata_i;
          out_d.block_end   = end_q;
          out_valid_d       = 1'b1;
        end
      end
      ST_K_RD: begin
        req_o.re    = 1'b1;
        req_o.raddr = k_q;
      end
      ST_K_ACC: begin
        si_d        = rdata_i;
        acc_d       = acc_q + rdata_i + key_byte(key_i, k_q[2:0]);
        req_o.re    = 1'b1;
        req_o.raddr = acc_q + rdata_i + key_byte(key_i, k_q[2:0]);
      end
      ST_K_WRK: begin
        req_o.we    = 1'b1;
        req_o.waddr = k_q;
        req_o.wdata = rdata_i;
      end
      ST_K_WRA: begin
        req_o.we    = 1'b1;
        req_o.waddr = acc_q;
        req_o.wdata = si_q;
        if (k_q == 8'hff) begin
          i_d = '0;
          j_d = '0;
        end else begin
          k_d         = k_q + 8'd1;
          req_o.re    = 1'b1;
          req_o.raddr = k_q + 8'd1;
        end
      end
      default: begin
        req_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    si_q   <= si_d;
    sj_q   <= sj_d;
    data_q <= data_d;
    end_q  <= end_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hdl/rc4_stream_cipher_unit.sv
// Channel   Direction  Handshake              Word
// cfg       in         cfg_valid_i/cfg_ready_o  session key, 40 bits
// in        in         in_valid_i/in_ready_o    mode, data_byte, buffer_end
// out       out        out_valid_o/out_ready_i  result_byte, block_end
//
// A crypt word is sequenced by the one read port and one write port of the permutation
// memory: two dependent reads, two writes for the swap, the keystream read sharing a
// cycle with the second write, and a final step that loads the result.
// A rekey word clears the valid bits, issues one first read and then runs the accumulate,
// write-k and write-accumulator states for each key schedule step.
// Reset leaves the identity table in place through per-entry valid bits, with no sweep.
// A result waits in the output register; a new word is taken while it waits, and the
// block stalls at the keystream step only if the previous result is still held.
module rc4_stream_cipher_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rc4_pkg::KeyBits-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rc4_pkg::in_word_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output rc4_pkg::out_word_t          out_data_o
);
  import rc4_pkg::*;

  logic [KeyBits-1:0]  key_q;
  perm_req_t           req;
  logic [ByteBits-1:0] rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      key_q <= cfg_data_i;
    end
  end

  rc4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (key_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .req_o       (req),
    .rdata_i     (rdata)
  );

  rc4_perm u_perm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rdata_o (rdata)
  );

endmodule

FILE: test/rc4_stream_cipher_unit_test.sv
`timescale 1ns / 1ps

module rc4_stream_cipher_unit_test;
  import rc4_pkg::*;

  localparam int SettleCycles  = 800;
  localparam int HoldOffCycles = 300;
  localparam int IdleLimit     = 20000;
  localparam int PhaseWords    = 55;

  typedef enum logic {
    ROW_WORD,
    ROW_KEY
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [KeyBits-1:0] key;
    in_word_t          word;
    logic              typed;
    out_word_t         want;
  } stim_row_t;

  typedef struct packed {
    logic      typed;
    out_word_t want;
  } offer_note_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [KeyBits-1:0] cfg_key = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_word_t           in_word = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_word_t          out_word;

  logic [7:0]         sbox_model [0:255];
  logic [7:0]         ks_i;
  logic [7:0]         ks_j;
  logic [KeyBits-1:0] key_model;

  out_word_t          pending_bytes [$];
  offer_note_t        offered_notes [$];
  stim_row_t          stim_rows [$];

  int                 mismatches = 0;
  int                 words_sent = 0;
  int                 rekeys_sent = 0;
  int                 bytes_checked = 0;
  int                 keys_written = 0;
  int                 idle_cycles = 0;
  bit                 pressure_done = 1'b0;

  rc4_stream_cipher_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_key),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic void cipher_rekey();
    logic [7:0] kb [0:7];
    logic [7:0] acc;
    logic [7:0] held;
    for (int n = 0; n < 5; n++) kb[n] = key_model[8*n +: 8];
    kb[5] = KeyTail0;
    kb[6] = KeyTail1;
    kb[7] = KeyTail2;
    for (int n = 0; n < 256; n++) sbox_model[n] = n[7:0];
    acc = '0;
    for (int n = 0; n < 256; n++) begin
      acc = acc + sbox_model[n] + kb[n % 8];
      held = sbox_model[n];
      sbox_model[n] = sbox_model[acc];
      sbox_model[acc] = held;
    end
    ks_i = '0;
    ks_j = '0;
  endfunction

  function automatic out_word_t cipher_byte(in_word_t w);
    out_word_t  r;
    logic [7:0] held;
    logic [7:0] sum;
    ks_i = ks_i + 8'd1;
    ks_j = ks_j + sbox_model[ks_i];
    held = sbox_model[ks_i];
    sbox_model[ks_i] = sbox_model[ks_j];
    sbox_model[ks_j] = held;
    sum = sbox_model[ks_i] + sbox_model[ks_j];
    r.result_byte = w.data_byte ^ sbox_model[sum];
    r.block_end = w.buffer_end;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_row(row_kind_e kind, logic [KeyBits-1:0] key, logic mode,
                                  logic [7:0] data, logic bend, logic typed,
                                  logic [7:0] want_byte);
    stim_row_t row;
    row.kind = kind;
    row.key = key;
    row.word.mode = mode;
    row.word.data_byte = data;
    row.word.buffer_end = bend;
    row.typed = typed;
    row.want.result_byte = want_byte;
    row.want.block_end = bend;
    stim_rows.push_back(row);
  endfunction

  task automatic offer_word(in_word_t w, logic typed, out_word_t want);
    int          gap;
    offer_note_t note;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    note.typed = typed;
    note.want = want;
    offered_notes.push_back(note);
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (w.mode == ModeRekey) rekeys_sent++;
  endtask

  task automatic write_key(logic [KeyBits-1:0] k);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    // A rekey word gives no result, so the schedule may still be running here.
    repeat (SettleCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_key <= k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    key_model = k;
    keys_written++;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    for (int n = 0; n < 256; n++) sbox_model[n] = n[7:0];
    ks_i = '0;
    ks_j = '0;
    key_model = '0;
  end

  always @(posedge clk) begin : word_monitor
    offer_note_t note;
    out_word_t   predicted;
    if (rst_n && in_valid && in_ready) begin
      note = offered_notes.pop_front();
      if (in_word.mode == ModeRekey) begin
        cipher_rekey();
      end else begin
        predicted = cipher_byte(in_word);
        pending_bytes.push_back(note.typed ? note.want : predicted);
      end
    end
  end

  always @(posedge clk) begin : byte_checker
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        $error("result word with no expectation waiting: %h", out_word);
        mismatches++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_word.result_byte !== want.result_byte) begin
          $error("result_byte: expected %h, actual %h", want.result_byte,
                 out_word.result_byte);
          mismatches++;
        end
        if (out_word.block_end !== want.block_end) begin
          $error("block_end: expected %b, actual %b", want.block_end, out_word.block_end);
          mismatches++;
        end
      end
      bytes_checked++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("Timed out after %0d cycles without a handshake.", IdleLimit);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : receiver
    int r;
    forever begin
      @(posedge clk);
      if (!pressure_done && bytes_checked >= 120) begin
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
        pressure_done = 1'b1;
        out_ready <= 1'b1;
        repeat ($urandom_range(5, 30)) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end else if (r < 90) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat ($urandom_range(10, 60)) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t          row;
    in_word_t           w;
    logic [KeyBits-1:0] phase_keys [0:4];
    int                 phase_start;
    int                 r;
    int                 n;
    bit                 long_done;

    // Rows with a typed result rely on the identity table left by reset.
    add_row(ROW_WORD, '0, ModeCrypt, 8'h00, 1'b0, 1'b1, 8'h02);
    add_row(ROW_WORD, '0, ModeCrypt, 8'hff, 1'b0, 1'b1, 8'hfa);
    add_row(ROW_WORD, '0, ModeCrypt, 8'ha5, 1'b1, 1'b1, 8'ha2);
    add_row(ROW_KEY, 40'hff_ffff_ffff, ModeCrypt, 8'h00, 1'b0, 1'b0, 8'h00);
    add_row(ROW_WORD, '0, ModeCrypt, 8'h3c, 1'b1, 1'b0, 8'h00);
    add_row(ROW_WORD, '0, ModeRekey, 8'hff, 1'b1, 1'b0, 8'h00);
    add_row(ROW_WORD, '0, ModeCrypt, 8'h00, 1'b0, 1'b0, 8'h00);
    add_row(ROW_WORD, '0, ModeCrypt, 8'hff, 1'b0, 1'b0, 8'h00);
    add_row(ROW_WORD, '0, ModeCrypt, 8'h80, 1'b0, 1'b0, 8'h00);
    add_row(ROW_WORD, '0, ModeCrypt, 8'h7f, 1'b1, 1'b0, 8'h00);
    add_row(ROW_KEY, 40'h00_0000_0000, ModeCrypt, 8'h00, 1'b0, 1'b0, 8'h00);
    add_row(ROW_WORD, '0, ModeRekey, 8'h00, 1'b0, 1'b0, 8'h00);
    add_row(ROW_WORD, '0, ModeCrypt, 8'h00, 1'b1, 1'b0, 8'h00);
    add_row(ROW_WORD, '0, ModeRekey, 8'ha5, 1'b1, 1'b0, 8'h00);
    add_row(ROW_WORD, '0, ModeRekey, 8'h5a, 1'b0, 1'b0, 8'h00);
    add_row(ROW_WORD, '0, ModeCrypt, 8'hff, 1'b0, 1'b0, 8'h00);
    add_row(ROW_WORD, '0, ModeCrypt, 8'h01, 1'b1, 1'b0, 8'h00);
    add_row(ROW_KEY, 40'h80_0000_0001, ModeCrypt, 8'h00, 1'b0, 1'b0, 8'h00);
    add_row(ROW_WORD, '0, ModeRekey, 8'h00, 1'b0, 1'b0, 8'h00);
    add_row(ROW_WORD, '0, ModeCrypt, 8'h00, 1'b0, 1'b0, 8'h00);
    add_row(ROW_WORD, '0, ModeCrypt, 8'hff, 1'b1, 1'b0, 8'h00);

    phase_keys[0] = 40'hff_ffff_ffff;
    phase_keys[1] = 40'h00_0000_0000;
    phase_keys[2] = 40'({$urandom, $urandom});
    phase_keys[3] = 40'({$urandom, $urandom});
    phase_keys[4] = 40'h55_aa_0f_f0_c3;
    long_done = 1'b0;

    @(posedge clk);
    while (!rst_n) @(posedge clk);

    foreach (stim_rows[k]) begin
      row = stim_rows[k];
      if (row.kind == ROW_KEY) write_key(row.key);
      else offer_word(row.word, row.typed, row.want);
    end

    for (int p = 0; p < 5; p++) begin
      write_key(phase_keys[p]);
      phase_start = words_sent;
      while (words_sent < phase_start + PhaseWords) begin
        r = $urandom_range(0, 9);
        if (r < 7) begin
          if ($urandom_range(0, 1) == 1) begin
            w.mode = ModeRekey;
            w.data_byte = 8'($urandom);
            w.buffer_end = 1'($urandom);
            offer_word(w, 1'b0, '0);
          end
          // One long buffer takes both indices around the table.
          if (p == 2 && !long_done) begin
            n = 280;
            long_done = 1'b1;
          end else if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(25, 60);
          end else begin
            n = $urandom_range(1, 16);
          end
          for (int k = 0; k < n; k++) begin
            w.mode = ModeCrypt;
            w.data_byte = 8'($urandom);
            w.buffer_end = (k == n - 1);
            offer_word(w, 1'b0, '0);
          end
        end else if (r < 9) begin
          n = $urandom_range(1, 12);
          for (int k = 0; k < n; k++) begin
            w.mode = ModeCrypt;
            w.data_byte = 8'($urandom);
            w.buffer_end = ($urandom_range(0, 3) == 0);
            offer_word(w, 1'b0, '0);
          end
          w.mode = ModeRekey;
          w.data_byte = 8'($urandom);
          w.buffer_end = 1'($urandom);
          offer_word(w, 1'b0, '0);
        end else begin
          w = 10'($urandom);
          offer_word(w, 1'b0, '0);
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (pending_bytes.size() != 0) begin
      $error("%0d result words never arrived", pending_bytes.size());
      mismatches++;
    end

    $display("Run covered %0d input words (%0d rekeys) and %0d checked result words,",
             words_sent, rekeys_sent, bytes_checked);
    $display("across %0d session keys, with a receiver hold-off of %0d cycles.",
             keys_written, HoldOffCycles);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/rc4_pkg.sv
hdl/rc4_perm.sv
hdl/rc4_ctrl.sv
hdl/rc4_stream_cipher_unit.sv
test/rc4_stream_cipher_unit_test.sv
